@@ rtl/mosa_pkg.sv @@
// Shared constants for the multichannel oversample averager.
// Used by mosa_div, multichannel_oversample_averager and the verif files; no dependencies.
package mosa_pkg;

  localparam int CHANNELS_DEF   = 8;
  localparam int COUNT_BITS_DEF = 16;

  localparam int CH_W       = 3;
  localparam int WORD_W     = 16;
  localparam int SUM_W      = 32;
  localparam int FRAC_BITS  = 8;
  localparam int NUM_W      = SUM_W + FRAC_BITS;
  localparam int AVG_W      = 20;
  localparam int OUTCNT_W   = 16;
  localparam int ITER_W     = $clog2(NUM_W + 1);
  localparam int DATA_SHIFT = 3;

  localparam logic [WORD_W-1:0] REJECT_MASK = 16'h8007;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

endpackage

@@ rtl/mosa_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module mosa_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/mosa_div.sv @@
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on mosa_pkg.
module mosa_div #(
  parameter int CNT_W = mosa_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mosa_pkg::NUM_W-1:0] numer,
  input  logic [CNT_W-1:0]           denom,
  output logic                       done,
  output logic [mosa_pkg::AVG_W-1:0] quot
);
  import mosa_pkg::*;

  logic              busy;
  logic [ITER_W-1:0] iter;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  den;
  logic [NUM_W-1:0]  nq;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  always_comb begin
    trial = {rem, nq[NUM_W-1]};
    ge    = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= ITER_W'(NUM_W);
        rem  <= '0;
        den  <= denom;
        nq   <= numer;
      end else if (busy) begin
        rem  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        nq   <= {nq[NUM_W-2:0], ge};
        iter <= iter - ITER_W'(1);
        if (iter == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = nq[AVG_W-1:0];

endmodule

@@ rtl/multichannel_oversample_averager.sv @@
// Per-channel oversampling accumulator with read-and-clear averaging.
// Depends on mosa_pkg, mosa_ram and mosa_div.
//
// Each input word is a sample or a read request for one channel. Sums and
// counts live in one RAM entry per channel; per-entry valid flops make all
// entries read as zero straight out of reset, so no clearing pass is needed.
// A sample (accepted or rejected) goes from acceptance through S_LOOK, where
// the RAM read and update happen, and S_DONE to the output register; a read
// of a non-empty channel also waits in S_DIV for the 40-step bit-serial
// divider. One word is in flight at a time; the output register holds a
// finished result while the next input word is accepted.
module multichannel_oversample_averager #(
  parameter int CHANNELS   = mosa_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = mosa_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [mosa_pkg::CH_W-1:0]     channel,
  input  logic [mosa_pkg::WORD_W-1:0]   raw_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          valid_res,
  output logic [mosa_pkg::AVG_W-1:0]    average,
  output logic [mosa_pkg::OUTCNT_W-1:0] sample_count
);
  import mosa_pkg::*;

  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENT_W = SUM_W + COUNT_BITS;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_DIV, S_DONE} state_t;

  state_t              state;
  logic                op_q;
  logic [AW-1:0]       ch_q;
  logic                oor_q;
  logic [WORD_W-1:0]   raw_q;
  logic [CHANNELS-1:0] ent_valid;
  logic                pend_vld;
  logic [AVG_W-1:0]    pend_avg;
  logic [OUTCNT_W-1:0] pend_cnt;

  logic [ENT_W-1:0]      rd_data;
  logic [ENT_W-1:0]      wr_data;
  logic                  ram_we;
  logic [SUM_W-1:0]      cur_sum;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [SUM_W-1:0]      new_sum;
  logic                  div_start;
  logic                  div_done;
  logic [AVG_W-1:0]      div_quot;
  logic                  res_vld;
  logic [OUTCNT_W-1:0]   res_cnt;
  logic                  out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  mosa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ch_q),
    .wr_data (wr_data),
    .rd_addr (AW'(channel)),
    .rd_data (rd_data)
  );

  mosa_div #(
    .CNT_W (COUNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer ({cur_sum, {FRAC_BITS{1'b0}}}),
    .denom (cur_cnt),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    cur_sum   = ent_valid[ch_q] ? rd_data[ENT_W-1:COUNT_BITS] : '0;
    cur_cnt   = ent_valid[ch_q] ? rd_data[COUNT_BITS-1:0] : '0;
    cnt_inc   = cur_cnt + COUNT_BITS'(1);
    cnt_new   = (cnt_inc == '0) ? COUNT_BITS'(1) : cnt_inc;
    new_sum   = ((cnt_inc == '0) ? '0 : cur_sum) + SUM_W'(raw_q >> DATA_SHIFT);
    ram_we    = 1'b0;
    wr_data   = '0;
    div_start = 1'b0;
    res_vld   = 1'b0;
    res_cnt   = '0;
    if (state == S_LOOK && !oor_q) begin
      if (op_q == OP_SAMPLE) begin
        if ((raw_q & REJECT_MASK) != '0) begin
          res_cnt = OUTCNT_W'(cur_cnt);
        end else begin
          ram_we  = 1'b1;
          wr_data = {new_sum, cnt_new};
          res_vld = 1'b1;
          res_cnt = OUTCNT_W'(cnt_new);
        end
      end else if (cur_cnt != '0) begin
        ram_we    = 1'b1;
        div_start = 1'b1;
        res_vld   = 1'b1;
        res_cnt   = OUTCNT_W'(cur_cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ent_valid <= '0;
    end else begin
      if (ram_we) begin
        ent_valid[ch_q] <= 1'b1;
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= op;
            ch_q  <= AW'(channel);
            oor_q <= (32'(channel) >= CHANNELS);
            raw_q <= raw_word;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          pend_vld <= res_vld;
          pend_cnt <= res_cnt;
          pend_avg <= '0;
          state    <= div_start ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_done) begin
            pend_avg <= div_quot;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            valid_res    <= pend_vld;
            average      <= pend_avg;
            sample_count <= pend_cnt;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_LOOK))
    else $error("accepted word did not start a lookup");

  a_write_in_look: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_LOOK))
    else $error("RAM write outside lookup");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished while not waiting");

  a_avg_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && average != '0) |-> valid_res)
    else $error("nonzero average on invalid result");
`endif

endmodule

@@ verif/mosa_average_checker.sv @@
`timescale 1ns / 1ps
// Checker for multichannel_oversample_averager: per-channel sum/count predictor
// and in-order result compare. Depends on mosa_pkg.
module mosa_average_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          op,
  input  logic [mosa_pkg::CH_W-1:0]     channel,
  input  logic [mosa_pkg::WORD_W-1:0]   raw_word,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          valid_res,
  input  logic [mosa_pkg::AVG_W-1:0]    average,
  input  logic [mosa_pkg::OUTCNT_W-1:0] sample_count,
  output int                            errors,
  output int                            pending
);
  import mosa_pkg::*;

  localparam int NCH   = CHANNELS_DEF;
  localparam int CNT_W = COUNT_BITS_DEF;

  typedef struct packed {
    logic                valid_res;
    logic [AVG_W-1:0]    average;
    logic [OUTCNT_W-1:0] sample_count;
  } avg_word_t;

  logic [SUM_W-1:0] ch_sum [NCH];
  logic [CNT_W-1:0] ch_cnt [NCH];
  avg_word_t        expected_avgs [$];
  avg_word_t        got;
  avg_word_t        want;
  int               reported;

  function automatic avg_word_t accumulate_or_dump(logic rd, logic [CH_W-1:0] ch,
                                                   logic [WORD_W-1:0] w);
    avg_word_t        r;
    logic [CNT_W-1:0] next_cnt;
    logic [NUM_W-1:0] quo;
    r = '0;
    if (int'(ch) >= NCH) return r;
    if (rd == OP_SAMPLE) begin
      if ((w & REJECT_MASK) != '0) begin
        r.sample_count = OUTCNT_W'(ch_cnt[ch]);
        return r;
      end
      next_cnt = ch_cnt[ch] + 1'b1;
      if (next_cnt == '0) begin
        ch_sum[ch] = '0;
        next_cnt   = CNT_W'(1);
      end
      ch_cnt[ch]     = next_cnt;
      ch_sum[ch]     = ch_sum[ch] + SUM_W'(w >> DATA_SHIFT);
      r.valid_res    = 1'b1;
      r.sample_count = OUTCNT_W'(next_cnt);
    end else if (ch_cnt[ch] != '0) begin
      quo            = (NUM_W'(ch_sum[ch]) << FRAC_BITS) / NUM_W'(ch_cnt[ch]);
      r.valid_res    = 1'b1;
      r.average      = quo[AVG_W-1:0];
      r.sample_count = OUTCNT_W'(ch_cnt[ch]);
      ch_sum[ch]     = '0;
      ch_cnt[ch]     = '0;
    end
    return r;
  endfunction

  function automatic void compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      if (reported < 40) $display("%0t: %s mismatch, expected %0d, actual %0d",
                                  $time, name, exp_v, act_v);
      reported++;
    end
  endfunction

  initial begin
    errors   = 0;
    pending  = 0;
    reported = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        ch_sum[i] = '0;
        ch_cnt[i] = '0;
      end
      expected_avgs.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.valid_res    = valid_res;
        got.average      = average;
        got.sample_count = sample_count;
        if (expected_avgs.size() == 0) begin
          errors++;
          if (reported < 40) $display("%0t: unexpected word, expected none, actual %h",
                                      $time, got);
          reported++;
        end else begin
          want = expected_avgs.pop_front();
          compare_field("valid_res", want.valid_res, got.valid_res);
          compare_field("average", want.average, got.average);
          compare_field("sample_count", want.sample_count, got.sample_count);
        end
      end
      if (in_valid && !in_stall)
        expected_avgs.push_back(accumulate_or_dump(op, channel, raw_word));
    end
    pending = expected_avgs.size();
  end

endmodule

@@ verif/tb_multichannel_oversample_averager.sv @@
`timescale 1ns / 1ps
// Top of the multichannel_oversample_averager testbench: clock, reset, stimulus
// and verdict. Depends on mosa_pkg, the averager RTL and mosa_average_checker.
module tb_multichannel_oversample_averager;
  import mosa_pkg::*;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                op;
  logic [CH_W-1:0]     channel;
  logic [WORD_W-1:0]   raw_word;
  logic                out_valid;
  logic                out_stall;
  logic                valid_res;
  logic [AVG_W-1:0]    average;
  logic [OUTCNT_W-1:0] sample_count;
  int                  errors;
  int                  pending;
  int                  src_idle_pct;
  int                  sink_idle_pct;

  multichannel_oversample_averager u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .channel(channel), .raw_word(raw_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .valid_res(valid_res), .average(average), .sample_count(sample_count)
  );

  mosa_average_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .channel(channel), .raw_word(raw_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .valid_res(valid_res), .average(average), .sample_count(sample_count),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_word(logic rd, logic [CH_W-1:0] ch, logic [WORD_W-1:0] w);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= rd;
    channel  <= ch;
    raw_word <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [WORD_W-1:0] clean_word(logic [11:0] data);
    return {1'b0, data, 3'b000};
  endfunction

  task automatic send_random();
    logic [11:0]       data;
    logic [WORD_W-1:0] w;
    logic              rd;
    case ($urandom_range(9))
      0:       data = 12'hFFF;
      1:       data = 12'h000;
      default: data = 12'($urandom_range(4095));
    endcase
    w  = ($urandom_range(99) < 75) ? clean_word(data) : 16'($urandom_range(65535));
    rd = ($urandom_range(99) < 22) ? OP_READ : OP_SAMPLE;
    send_word(rd, 3'($urandom_range(7)), w);
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    op            = OP_SAMPLE;
    channel       = '0;
    raw_word      = '0;
    src_idle_pct  = 34;
    sink_idle_pct = 65;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty read, data extremes, then rejects on an empty and a filled channel
    send_word(OP_READ, 3'd0, 16'hFFFF);
    send_word(OP_SAMPLE, 3'd0, clean_word(12'h000));
    send_word(OP_SAMPLE, 3'd0, clean_word(12'hFFF));
    send_word(OP_READ, 3'd0, 16'h0000);
    send_word(OP_READ, 3'd0, 16'h0000);
    send_word(OP_SAMPLE, 3'd7, 16'h8000);
    send_word(OP_SAMPLE, 3'd7, 16'h0001);
    send_word(OP_SAMPLE, 3'd7, 16'h0004);
    send_word(OP_SAMPLE, 3'd7, 16'hFFFF);
    send_word(OP_SAMPLE, 3'd7, 16'h7FF8);
    send_word(OP_SAMPLE, 3'd7, 16'h0002);
    send_word(OP_READ, 3'd7, 16'h5555);
    for (int c = 1; c < 7; c++) begin
      send_word(OP_SAMPLE, 3'(c), clean_word(12'(c * 600 + 1)));
      send_word(OP_SAMPLE, 3'(c), clean_word(12'(c * 37)));
    end

    repeat (209) send_random();
    src_idle_pct  = 65;
    sink_idle_pct = 34;
    repeat (209) send_random();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    repeat (208) send_random();
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
